### src/pecm_pkg.sv
// Package for the pinned entry cache manager.
// Holds the sizes, operation and status codes, entry and result types used by all files but the entry RAM.
// No dependencies.
package pecm_pkg;

  // Table size and field widths.
  localparam int ENTRIES = 16;
  localparam int SLOT_W  = 4;
  localparam int KEY_W   = 32;
  localparam int PIN_W   = 8;
  localparam int CNT_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [PIN_W-1:0] PIN_MAX       = {PIN_W{1'b1}};
  localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(16);

  // Register index of the only configuration register.
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PIN   = 2'd0,
    FN_UNPIN = 2'd1,
    FN_READ  = 2'd2,
    FN_WRITE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_e;

  // One entry as held in the entry RAM.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PIN_W-1:0] pins;
    logic             dirty;
  } entry_t;

  // Outcome of the parallel tag search.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              free_valid;
  } tag_lookup_t;

  // Tag write issued with each entry update.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              idle;
  } tag_update_t;

  // One result beat.
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              fill_request;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic              writeback_request;
    logic [PIN_W-1:0]  pin_count;
    logic              list_done;
  } rsp_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [SLOT_W-1:0] first_index(logic [ENTRIES-1:0] v);
    logic [ENTRIES-1:0] onehot;
    logic [SLOT_W-1:0]  idx;
    onehot = v & (~v + 1'b1);
    idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (onehot[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### src/pecm_req_if.sv
// Request channel of the pinned entry cache manager.
// Depends on pecm_pkg for the field widths.
interface pecm_req_if;
  logic                         valid;
  logic                         ready;
  logic [pecm_pkg::FUNC_W-1:0]  func;
  logic [pecm_pkg::KEY_W-1:0]   key;
  logic                         last_of_list;

  modport source (output valid, output func, output key, output last_of_list, input ready);
  modport sink   (input valid, input func, input key, input last_of_list, output ready);
endinterface

### src/pecm_rsp_if.sv
// Result channel of the pinned entry cache manager.
// Depends on pecm_pkg for the field widths.
interface pecm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [pecm_pkg::SLOT_W-1:0]  slot;
  logic                         fill_request;
  logic                         evicted;
  logic [pecm_pkg::KEY_W-1:0]   evicted_key;
  logic                         writeback_request;
  logic [pecm_pkg::PIN_W-1:0]   pin_count;
  logic                         list_done;

  modport source (output valid, output status, output slot, output fill_request,
                  output evicted, output evicted_key, output writeback_request,
                  output pin_count, output list_done, input ready);
  modport sink   (input valid, input status, input slot, input fill_request,
                  input evicted, input evicted_key, input writeback_request,
                  input pin_count, input list_done, output ready);
endinterface

### src/pecm_cfg_regs.sv
// APB-style configuration register block holding entries_in_use.
// Depends on pecm_pkg.
module pecm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pecm_pkg::PADDR_W-1:0]  paddr,
  input  logic [pecm_pkg::DATA_W-1:0]   pwdata,
  output logic [pecm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [pecm_pkg::CNT_W-1:0]    entries_o
);
  import pecm_pkg::*;

  logic [CNT_W-1:0] entries_q, entries_d;
  logic             reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ENTRIES_IN_USE);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  // Register write; writes with paddr[2] set are dropped.
  always_comb begin
    entries_d = entries_q;
    if (wr_en) begin
      entries_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
    end else begin
      entries_q <= entries_d;
    end
  end

  // Read back.
  assign prdata    = reg_sel ? DATA_W'(entries_q) : '0;
  assign entries_o = entries_q;

endmodule

### src/pecm_entry_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module pecm_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/pecm_tag_array.sv
// Tag array: valid bits, keys and idle marks of every slot with parallel key match
// and lowest-free-slot search. Depends on pecm_pkg.
module pecm_tag_array (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pecm_pkg::KEY_W-1:0]  lookup_key_i,
  input  logic [pecm_pkg::CNT_W-1:0]  limit_i,
  output pecm_pkg::tag_lookup_t       lookup_o,
  input  pecm_pkg::tag_update_t       update_i
);
  import pecm_pkg::*;

  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] idle_q;
  logic [KEY_W-1:0]   key_q [ENTRIES];

  logic [CNT_W-1:0]   eff_limit;
  logic [ENTRIES-1:0] in_range;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] free;

  // Slots beyond the table size are never searched.
  assign eff_limit = (limit_i > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : limit_i;

  // Per-slot compare against the requested key and free test.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_range[i] = (CNT_W'(i) < eff_limit);
      match[i]    = in_range[i] && valid_q[i] && (key_q[i] == lookup_key_i);
      free[i]     = in_range[i] && (!valid_q[i] || idle_q[i]);
    end
  end

  // Lowest matching and lowest free slot.
  always_comb begin
    lookup_o.hit        = |match;
    lookup_o.hit_slot   = first_index(match);
    lookup_o.free_found = |free;
    lookup_o.free_slot  = first_index(free);
    lookup_o.free_valid = valid_q[lookup_o.free_slot];
  end

  // Valid and idle marks clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idle_q  <= '0;
    end else if (update_i.we) begin
      valid_q[update_i.slot] <= 1'b1;
      idle_q[update_i.slot]  <= update_i.idle;
    end
  end

  // Keys are only compared behind a valid bit and need no reset.
  always_ff @(posedge clk_i) begin
    if (update_i.we) begin
      key_q[update_i.slot] <= update_i.key;
    end
  end

endmodule

### src/pecm_ctrl.sv
// Request sequencer: lookup cycle with entry RAM read, then update cycle with
// write-back and result register. Depends on pecm_pkg and the channel interfaces.
module pecm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pecm_req_if.sink                     req,
  pecm_rsp_if.source                   rsp,
  output logic [pecm_pkg::KEY_W-1:0]   lookup_key_o,
  input  pecm_pkg::tag_lookup_t        lookup_i,
  output pecm_pkg::tag_update_t        update_o,
  output logic                         ram_re_o,
  output logic [pecm_pkg::SLOT_W-1:0]  ram_raddr_o,
  output logic                         ram_we_o,
  output logic [pecm_pkg::SLOT_W-1:0]  ram_waddr_o,
  output pecm_pkg::entry_t             ram_wdata_o,
  input  pecm_pkg::entry_t             ram_rdata_i
);
  import pecm_pkg::*;

  state_e            state_q, state_d;
  func_e             func_q;
  logic [KEY_W-1:0]  key_q;
  logic              last_q;
  logic              hit_q, inst_q, evict_q;
  logic [SLOT_W-1:0] slot_q;
  logic              out_valid_q, out_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              in_fire, out_fire, upd_done;
  logic              look_slot_sel;
  entry_t            new_entry;
  logic              entry_we;
  logic [PIN_W-1:0]  pins_inc, pins_dec;

  assign in_fire  = req.valid && req.ready;
  assign out_fire = rsp.valid && rsp.ready;
  assign upd_done = (state_q == S_UPD) && (!out_valid_q || rsp.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (upd_done) begin
          state_d = in_fire ? S_LOOK : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A new request enters while idle or as the update in flight completes.
  assign req.ready = (state_q == S_IDLE) || upd_done;

  // Lookup cycle: read the entry of the hit slot, or of the free slot on a miss.
  assign lookup_key_o  = key_q;
  assign look_slot_sel = lookup_i.hit;
  assign ram_re_o      = (state_q == S_LOOK);
  assign ram_raddr_o   = look_slot_sel ? lookup_i.hit_slot : lookup_i.free_slot;

  assign pins_inc = (ram_rdata_i.pins == PIN_MAX) ? PIN_MAX : ram_rdata_i.pins + 1'b1;
  assign pins_dec = (ram_rdata_i.pins == '0) ? '0 : ram_rdata_i.pins - 1'b1;

  // Update cycle: modify the entry and form the result.
  always_comb begin
    new_entry = ram_rdata_i;
    entry_we  = 1'b0;
    rsp_d     = '0;
    rsp_d.status    = ST_MISS;
    rsp_d.list_done = last_q;
    case (func_q)
      FN_PIN: begin
        if (hit_q) begin
          new_entry.pins = pins_inc;
          entry_we       = 1'b1;
          rsp_d.status   = ST_HIT;
        end else if (inst_q) begin
          new_entry.key      = key_q;
          new_entry.pins     = PIN_W'(1);
          new_entry.dirty    = 1'b0;
          entry_we           = 1'b1;
          rsp_d.status       = ST_NEW;
          rsp_d.fill_request = 1'b1;
          rsp_d.evicted      = evict_q;
          rsp_d.evicted_key  = evict_q ? ram_rdata_i.key : '0;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      FN_UNPIN: begin
        if (hit_q) begin
          new_entry.pins = pins_dec;
          entry_we       = 1'b1;
          rsp_d.status   = ST_HIT;
          // Dirty entry left with no pins goes back to storage.
          if (ram_rdata_i.dirty && (pins_dec == '0)) begin
            new_entry.dirty         = 1'b0;
            rsp_d.writeback_request = 1'b1;
          end
        end
      end
      FN_READ: begin
        if (hit_q) begin
          entry_we     = 1'b1;
          rsp_d.status = ST_HIT;
        end
      end
      FN_WRITE: begin
        if (hit_q) begin
          new_entry.dirty = 1'b1;
          entry_we        = 1'b1;
          rsp_d.status    = ST_HIT;
        end
      end
      default: begin
        rsp_d.status = ST_MISS;
      end
    endcase
    if (entry_we) begin
      rsp_d.slot      = slot_q;
      rsp_d.pin_count = new_entry.pins;
    end
  end

  // Write-back to the entry RAM and the tag array.
  assign ram_we_o    = upd_done && entry_we;
  assign ram_waddr_o = slot_q;
  assign ram_wdata_o = new_entry;

  assign update_o.we   = upd_done && entry_we;
  assign update_o.slot = slot_q;
  assign update_o.key  = new_entry.key;
  assign update_o.idle = !new_entry.dirty && (new_entry.pins == '0);

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (upd_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      inst_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_LOOK) begin
        hit_q  <= lookup_i.hit;
        inst_q <= !lookup_i.hit && (func_q == FN_PIN) && lookup_i.free_found;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_e'(req.func);
      key_q  <= req.key;
      last_q <= req.last_of_list;
    end
    if (state_q == S_LOOK) begin
      slot_q  <= ram_raddr_o;
      evict_q <= lookup_i.free_valid;
    end
    if (upd_done) begin
      rsp_q <= rsp_d;
    end
  end

  // Result beat.
  assign rsp.valid             = out_valid_q;
  assign rsp.status            = rsp_q.status;
  assign rsp.slot              = rsp_q.slot;
  assign rsp.fill_request      = rsp_q.fill_request;
  assign rsp.evicted           = rsp_q.evicted;
  assign rsp.evicted_key       = rsp_q.evicted_key;
  assign rsp.writeback_request = rsp_q.writeback_request;
  assign rsp.pin_count         = rsp_q.pin_count;
  assign rsp.list_done         = rsp_q.list_done;

endmodule

### src/pinned_entry_cache_manager.sv
// Top level of the pinned entry cache manager: tag array, entry RAM, sequencer, registers.
// Depends on pecm_pkg, pecm_req_if, pecm_rsp_if and the pecm_* modules.
//
//   channel   direction  handshake              beat contents
//   req       in         valid/ready            func, key, last_of_list
//   rsp       out        valid/ready            status, slot, fill/evict/writeback, pins
//   apb cfg   in         psel/penable, pready=1 entries_in_use at addresses 0-3
//
// A request passes through a lookup cycle that matches the key against all slot tags
// and reads the chosen entry from the entry RAM, then an update cycle that writes the
// entry back and loads the result register.
// Reset clears valid and idle marks at once; the entry RAM needs no clearing pass.
// The update cycle holds while the previous result beat has not been taken.
module pinned_entry_cache_manager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pecm_req_if.sink                      req,
  pecm_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pecm_pkg::PADDR_W-1:0]  paddr,
  input  logic [pecm_pkg::DATA_W-1:0]   pwdata,
  output logic [pecm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import pecm_pkg::*;

  logic [CNT_W-1:0]  entries;
  logic [KEY_W-1:0]  lookup_key;
  tag_lookup_t       lookup;
  tag_update_t       update;
  logic              ram_re, ram_we;
  logic [SLOT_W-1:0] ram_raddr, ram_waddr;
  entry_t            ram_wdata, ram_rdata;

  pecm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .entries_o (entries)
  );

  pecm_tag_array u_tags (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_key_i (lookup_key),
    .limit_i      (entries),
    .lookup_o     (lookup),
    .update_i     (update)
  );

  pecm_entry_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  ($bits(entry_t)),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pecm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .rsp          (rsp),
    .lookup_key_o (lookup_key),
    .lookup_i     (lookup),
    .update_o     (update),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata)
  );

endmodule

### src/pecm_checker.sv
// Port-level checker for the pinned entry cache manager and its bind statement.
// Depends on pecm_pkg and on the top level's ports.
module pecm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  rsp_status,
  input logic                        rsp_fill,
  input logic                        rsp_evicted,
  input logic                        rsp_writeback,
  input logic [pecm_pkg::PIN_W-1:0]  rsp_pins
);
  import pecm_pkg::*;

  // A stalled result beat stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  // A fresh result follows an accepted request by the lookup and update cycles.
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
    else $error("result beat without a matching request");

  // Fill and eviction come only with a new install, writeback only with a hit.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> ((rsp_fill == (rsp_status == ST_NEW)) &&
                   (!rsp_evicted || (rsp_status == ST_NEW)) &&
                   (!rsp_writeback || (rsp_status == ST_HIT))))
    else $error("result flags disagree with status");

  // A request that found no entry reports no pin count.
  a_no_slot_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_MISS)) |-> (rsp_pins == '0))
    else $error("pin count reported without an entry");

endmodule

bind pinned_entry_cache_manager pecm_checker u_pecm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_fill      (rsp.fill_request),
  .rsp_evicted   (rsp.evicted),
  .rsp_writeback (rsp.writeback_request),
  .rsp_pins      (rsp.pin_count)
);
